// ----- hdl/bpa_pkg.sv -----
// Shared types and constants of the bitmap page allocator.
package bpa_pkg;

   localparam int BPA_FIELD_W  = 13;
   localparam int BPA_ADDR_W   = 48;
   localparam int BPA_WORD_BITS = 32;
   localparam int BPA_WORD_SHIFT = 5;
   localparam int BPA_CSR_IDX_W = 1;

   localparam logic [BPA_CSR_IDX_W-1:0] BPA_CSR_MEMORY_BASE    = 1'b0;
   localparam logic [BPA_CSR_IDX_W-1:0] BPA_CSR_RESERVED_COUNT = 1'b1;

   typedef enum logic [1:0] {
      OP_INIT  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2
   } bpa_op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FREE   = 2'd1,
      ST_NO_FIT    = 2'd2,
      ST_BAD_FREE  = 2'd3
   } bpa_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_INIT_WR,
      S_SCAN_RD,
      S_SCAN_EVAL,
      S_FREE_RANGE,
      S_MOD_RD,
      S_MOD_WR,
      S_RESP
   } bpa_state_type;

   typedef struct packed {
      bpa_op_type                opcode;
      logic [BPA_FIELD_W-1:0]    page_count;
      logic [BPA_ADDR_W-1:0]     release_address;
   } bpa_req_type;

   typedef struct packed {
      bpa_status_type            status;
      logic [BPA_ADDR_W-1:0]     run_address;
      logic [BPA_FIELD_W-1:0]    used_total;
      logic [BPA_FIELD_W-1:0]    free_total;
   } bpa_rsp_type;

endpackage

// ----- hdl/bitmap_page_allocator.sv -----
// Next-fit bitmap page allocator: used map, scan sequencer and counters.
//
// Usage: one request at a time enters on the req_ channel (valid/ready) and
// yields exactly one response on the rsp_ channel. Opcode init rebuilds the map,
// alloc searches a run of free pages next-fit from the cursor (and once more
// from page zero), free clears a run given by address and page count.
// The map is a word memory of 32 pages per word; one shared shift and trailing-count
// unit steps over one stretch of equal bits per cycle, pausing to read each word.
// Steps: init writes each map word in turn; alloc reads each map word and
// steps over each free/used boundary inside it, then reads and writes each
// word of the run it marks; free reads and writes each word it clears.
// A new request is taken only once the last one is done: req_ready is high
// only while the sequencer is idle. The memory read/modify/write port sets the pace.
// Reset: the configuration returns to base 0 and one reserved page, and a
// pass over every map word rewrites the map with page zero marked used;
// no request is taken during it, configuration writes are taken as ever.
// Stall: a finished response waits in the output register; the next request
// is still accepted, and its response waits until the held one is taken.
module bitmap_page_allocator #(
   parameter int TOTAL_PAGES = 4096,
   parameter int PAGE_SHIFT  = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  bpa_pkg::bpa_req_type                   req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output bpa_pkg::bpa_rsp_type                   rsp_payload,
   input  logic                                   csr_we,
   input  logic [bpa_pkg::BPA_CSR_IDX_W-1:0]      csr_index,
   input  logic [bpa_pkg::BPA_ADDR_W-1:0]         csr_wdata
);
   import bpa_pkg::*;

   // Map geometry: words of W pages, NW words, positions wide enough to reach
   // the end of the last word.
   localparam int W  = BPA_WORD_BITS;
   localparam int OB = BPA_WORD_SHIFT;
   localparam int SW = OB + 1;
   localparam int NW = (TOTAL_PAGES + W - 1) / W;
   localparam int AW = (NW > 1) ? $clog2(NW) : 1;
   localparam int PW = $clog2(NW * W + 1);
   localparam int CW = $clog2(TOTAL_PAGES + 1);
   localparam int XW = ((PW > BPA_FIELD_W) ? PW : BPA_FIELD_W) + 1;
   localparam logic [W-1:0] ONES = '1;

   // Count trailing zeros of a map word; all zero gives W.
   function automatic logic [SW-1:0] ctz(input logic [W-1:0] v);
      logic [SW-1:0] n;
      n = SW'(W);
      for (int i = W - 1; i >= 0; i--) begin
         if (v[i]) n = SW'(i);
      end
      return n;
   endfunction

   // Bits of word wi that fall inside pages lo..hi.
   function automatic logic [W-1:0] range_mask(input logic [AW-1:0] wi,
                                                input logic [PW-1:0] lo,
                                                input logic [PW-1:0] hi);
      logic [PW-1:0] wbase;
      logic [OB-1:0] lo_off;
      logic [OB-1:0] hi_off;
      logic [W-1:0]  m;
      wbase  = PW'({wi, {OB{1'b0}}});
      lo_off = (lo > wbase) ? OB'(lo - wbase) : '0;
      hi_off = (hi >= wbase + PW'(W - 1)) ? OB'(W - 1) : OB'(hi - wbase);
      m = (ONES << lo_off) & (ONES >> (OB'(W - 1) - hi_off));
      if (hi < wbase) m = '0;
      return m;
   endfunction

   function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                             input logic [BPA_FIELD_W-1:0] b);
      logic [XW-1:0] s;
      s = XW'(a) + XW'(b);
      return (s > XW'(TOTAL_PAGES)) ? CW'(TOTAL_PAGES) : CW'(s);
   endfunction

   function automatic logic [CW-1:0] sat_sub(input logic [CW-1:0] a,
                                             input logic [BPA_FIELD_W-1:0] b);
      return (XW'(a) < XW'(b)) ? '0 : CW'(XW'(a) - XW'(b));
   endfunction

   // Configuration registers.
   logic [BPA_ADDR_W-1:0]  base_ff;
   logic [BPA_FIELD_W-1:0] rsv_ff;

   // Sequencer state and working registers.
   bpa_state_type          state_ff, state_in;
   bpa_op_type             op_ff, op_in;
   logic [BPA_FIELD_W-1:0] cnt_ff, cnt_in;
   logic [BPA_ADDR_W-1:0]  addr_ff, addr_in;
   logic [PW-1:0]          cursor_ff, cursor_in;
   logic [CW-1:0]          used_ff, used_in;
   logic [CW-1:0]          free_ff, free_in;
   logic [PW-1:0]          pos_ff, pos_in;
   logic [XW-1:0]          run_len_ff, run_len_in;
   logic [PW-1:0]          run_start_ff, run_start_in;
   logic                   pass_ff, pass_in;
   logic [PW-1:0]          lo_ff, lo_in;
   logic [PW-1:0]          hi_ff, hi_in;
   logic [AW-1:0]          wi_ff, wi_in;
   logic                   range_ok_ff, range_ok_in;
   logic                   set_ff, set_in;
   logic                   boot_ff, boot_in;
   logic [BPA_ADDR_W:0]    diff_ff, diff_in;
   bpa_status_type         status_ff, status_in;
   logic [BPA_ADDR_W-1:0]  run_addr_ff, run_addr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   bpa_rsp_type            rsp_data_ff, rsp_data_in;

   // Map memory.
   logic [W-1:0]  map_mem [NW];
   logic [W-1:0]  rdata_ff;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [W-1:0]  mem_wdata;

   // Shared scan unit: shift the current word down to the position, then
   // count the stretch of equal bits that starts there.
   logic [OB-1:0]  scan_off;
   logic [PW-1:0]  scan_wbase;
   logic [W-1:0]   scan_pad;
   logic [W-1:0]   scan_x;
   logic [W-1:0]   scan_y;
   logic [SW-1:0]  scan_z;
   logic [SW-1:0]  scan_avail;
   logic [SW-1:0]  scan_step;
   logic [PW-1:0]  scan_start;
   logic [XW-1:0]  scan_len;
   logic [XW-1:0]  cnt1;
   logic           scan_hit;
   logic [PW-1:0]  scan_end;

   // Free range unit.
   logic [BPA_ADDR_W-1:0] fr_page;
   logic                  fr_clear;
   logic [XW-1:0]         fr_last;
   logic [PW-1:0]         fr_hi;

   always_comb begin
      cnt1       = (cnt_ff == '0) ? XW'(1) : XW'(cnt_ff);
      scan_off   = pos_ff[OB-1:0];
      scan_wbase = PW'({pos_ff[OB +: AW], {OB{1'b0}}});
      // Pages beyond the map read as used.
      if ({1'b0, scan_wbase} + (PW + 1)'(W) > (PW + 1)'(TOTAL_PAGES)) begin
         scan_pad = ONES << OB'(PW'(TOTAL_PAGES) - scan_wbase);
      end else begin
         scan_pad = '0;
      end
      scan_x     = ((rdata_ff | scan_pad) >> scan_off) | ~(ONES >> scan_off);
      scan_y     = scan_x[0] ? ~scan_x : scan_x;
      scan_z     = ctz(scan_y);
      scan_avail = SW'(W) - SW'(scan_off);
      scan_step  = (scan_x[0] && (scan_z > scan_avail)) ? scan_avail : scan_z;
      scan_start = (run_len_ff == '0) ? pos_ff : run_start_ff;
      scan_len   = run_len_ff + XW'(scan_step);
      scan_hit   = !scan_x[0] && (scan_len >= cnt1);
      scan_end   = PW'(XW'(scan_start) + cnt1 - XW'(1));

      fr_page  = diff_ff[BPA_ADDR_W-1:0] >> PAGE_SHIFT;
      fr_clear = !diff_ff[BPA_ADDR_W] && (fr_page < BPA_ADDR_W'(TOTAL_PAGES))
                 && (cnt_ff != '0);
      fr_last  = XW'(fr_page[PW-1:0]) + XW'(cnt_ff) - XW'(1);
      fr_hi    = (fr_last > XW'(TOTAL_PAGES - 1)) ? PW'(TOTAL_PAGES - 1) : PW'(fr_last);
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Next state, datapath updates and memory control.
   always_comb begin
      logic [XW-1:0] r;
      state_in     = state_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      cursor_in    = cursor_ff;
      used_in      = used_ff;
      free_in      = free_ff;
      pos_in       = pos_ff;
      run_len_in   = run_len_ff;
      run_start_in = run_start_ff;
      pass_in      = pass_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      wi_in        = wi_ff;
      range_ok_in  = range_ok_ff;
      set_in       = set_ff;
      boot_in      = boot_ff;
      diff_in      = diff_ff;
      status_in    = status_ff;
      run_addr_in  = run_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_re       = 1'b0;
      mem_raddr    = pos_ff[OB +: AW];
      mem_we       = 1'b0;
      mem_waddr    = wi_ff;
      mem_wdata    = '0;
      r = (XW'(rsv_ff) > XW'(TOTAL_PAGES)) ? XW'(TOTAL_PAGES) : XW'(rsv_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_payload.opcode;
               cnt_in   = req_payload.page_count;
               addr_in  = req_payload.release_address;
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            status_in   = ST_OK;
            run_addr_in = '0;
            case (op_ff)
               OP_INIT: begin
                  cursor_in   = PW'(r);
                  used_in     = CW'(r);
                  free_in     = CW'(XW'(TOTAL_PAGES) - r);
                  hi_in       = PW'(r - XW'(1));
                  range_ok_in = (r != '0);
                  wi_in       = '0;
                  boot_in     = 1'b0;
                  state_in    = S_INIT_WR;
               end
               OP_ALLOC: begin
                  if (free_ff == '0) begin
                     status_in = ST_NO_FREE;
                     state_in  = S_RESP;
                  end else begin
                     pos_in     = cursor_ff;
                     run_len_in = '0;
                     pass_in    = 1'b0;
                     state_in   = S_SCAN_RD;
                  end
               end
               OP_FREE: begin
                  if (XW'(used_ff) <= XW'(rsv_ff)) begin
                     status_in = ST_BAD_FREE;
                     state_in  = S_RESP;
                  end else begin
                     used_in  = sat_sub(used_ff, cnt_ff);
                     free_in  = sat_add(free_ff, cnt_ff);
                     diff_in  = {1'b0, addr_ff} - {1'b0, base_ff};
                     state_in = S_FREE_RANGE;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         S_INIT_WR: begin
            mem_we    = 1'b1;
            mem_wdata = range_ok_ff ? range_mask(wi_ff, '0, hi_ff) : '0;
            if (wi_ff == AW'(NW - 1)) begin
               state_in = boot_ff ? S_IDLE : S_RESP;
               boot_in  = 1'b0;
            end else begin
               wi_in = wi_ff + AW'(1);
            end
         end

         S_SCAN_RD: begin
            if (pos_ff >= PW'(TOTAL_PAGES)) begin
               if (!pass_ff) begin
                  // restart once from page zero
                  pos_in     = '0;
                  run_len_in = '0;
                  pass_in    = 1'b1;
               end else begin
                  cursor_in = PW'(TOTAL_PAGES);
                  status_in = ST_NO_FIT;
                  state_in  = S_RESP;
               end
            end else begin
               mem_re   = 1'b1;
               state_in = S_SCAN_EVAL;
            end
         end

         S_SCAN_EVAL: begin
            if (scan_hit) begin
               cursor_in   = scan_end;
               run_addr_in = base_ff + (BPA_ADDR_W'(scan_start) << PAGE_SHIFT);
               used_in     = sat_add(used_ff, cnt_ff);
               free_in     = sat_sub(free_ff, cnt_ff);
               if (cnt_ff != '0) begin
                  lo_in    = scan_start;
                  hi_in    = scan_end;
                  set_in   = 1'b1;
                  wi_in    = scan_start[OB +: AW];
                  state_in = S_MOD_RD;
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               if (scan_x[0]) begin
                  run_len_in = '0;
               end else begin
                  run_len_in   = scan_len;
                  run_start_in = scan_start;
               end
               pos_in = PW'(pos_ff + PW'(scan_step));
               if (scan_step == scan_avail) state_in = S_SCAN_RD;
            end
         end

         S_FREE_RANGE: begin
            if (fr_clear) begin
               lo_in    = fr_page[PW-1:0];
               hi_in    = fr_hi;
               set_in   = 1'b0;
               wi_in    = fr_page[OB +: AW];
               state_in = S_MOD_RD;
            end else begin
               state_in = S_RESP;
            end
         end

         S_MOD_RD: begin
            mem_re    = 1'b1;
            mem_raddr = wi_ff;
            state_in  = S_MOD_WR;
         end

         S_MOD_WR: begin
            mem_we    = 1'b1;
            mem_wdata = set_ff ? (rdata_ff | range_mask(wi_ff, lo_ff, hi_ff))
                               : (rdata_ff & ~range_mask(wi_ff, lo_ff, hi_ff));
            if (wi_ff == hi_ff[OB +: AW]) begin
               state_in = S_RESP;
            end else begin
               wi_in    = wi_ff + AW'(1);
               state_in = S_MOD_RD;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = status_ff;
               rsp_data_in.run_address = run_addr_ff;
               rsp_data_in.used_total  = BPA_FIELD_W'(used_ff);
               rsp_data_in.free_total  = BPA_FIELD_W'(free_ff);
               state_in                = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT_WR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         rsv_ff  <= BPA_FIELD_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            BPA_CSR_MEMORY_BASE:    base_ff <= csr_wdata;
            BPA_CSR_RESERVED_COUNT: rsv_ff  <= csr_wdata[BPA_FIELD_W-1:0];
            default: ;
         endcase
      end
   end

   // Reset behaves as an init with one reserved page.
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= PW'(1);
         used_ff      <= CW'(1);
         free_ff      <= CW'(TOTAL_PAGES - 1);
         hi_ff        <= '0;
         range_ok_ff  <= 1'b1;
         wi_ff        <= '0;
         boot_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         used_ff      <= used_in;
         free_ff      <= free_in;
         hi_ff        <= hi_in;
         range_ok_ff  <= range_ok_in;
         wi_ff        <= wi_in;
         boot_ff      <= boot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      cnt_ff       <= cnt_in;
      addr_ff      <= addr_in;
      pos_ff       <= pos_in;
      run_len_ff   <= run_len_in;
      run_start_ff <= run_start_in;
      pass_ff      <= pass_in;
      lo_ff        <= lo_in;
      set_ff       <= set_in;
      diff_ff      <= diff_in;
      status_ff    <= status_in;
      run_addr_ff  <= run_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) map_mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (mem_re) rdata_ff <= map_mem[mem_raddr];
   end

   // Used plus free always covers the whole map.
   a_counter_sum : assert property (@(posedge clock) disable iff (reset)
      XW'(used_ff) + XW'(free_ff) == XW'(TOTAL_PAGES))
      else $error("used and free counters do not add up to the map size");

   a_cursor_bound : assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= PW'(TOTAL_PAGES))
      else $error("scan cursor beyond the map");

   a_run_below_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_EVAL) |-> (run_len_ff < cnt1))
      else $error("scan kept going after the run was long enough");

   a_word_sweep_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD_WR) |-> (wi_ff <= hi_ff[OB +: AW]))
      else $error("map update went past the last word of the run");

   a_rsp_from_resp : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("response raised outside the response step");

endmodule
